### rtl/rpfr_pkg.sv
package rpfr_pkg;

	// Geometry of the page cache.
	localparam int FRAMES    = 16;
	localparam int FRAME_W   = $clog2(FRAMES);
	localparam int LOC_W     = 27;
	localparam int SIZE_W    = 28;
	localparam int OFFS_W    = 16;
	localparam int PAGE_W    = LOC_W - OFFS_W;
	localparam int STAMP_W   = 32;
	localparam int ADDR_W    = 32;

	localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAMES - 1);

	// One entry of the frame table as seen on its read port.
	typedef struct packed {
		logic               busy;
		logic [PAGE_W-1:0]  owner;
		logic [STAMP_W-1:0] stamp;
	} frame_entry_t;

	// Write request into the frame table.
	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] idx;
		logic               owner_en;
		logic [PAGE_W-1:0]  owner;
		logic [STAMP_W-1:0] stamp;
	} frame_wr_t;

	// Verdict of the shared compare unit on one frame.
	typedef struct packed {
		logic match;
		logic free;
		logic older;
	} cmp_res_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

endpackage

### rtl/rpfr_frame_tbl.sv
module rpfr_frame_tbl
	import rpfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [FRAME_W-1:0] rd_idx,
	output frame_entry_t       rd_entry,
	input  frame_wr_t          wr
);

	logic [PAGE_W-1:0]  owner_q [FRAMES];
	logic [STAMP_W-1:0] stamp_q [FRAMES];
	logic [FRAMES-1:0]  busy_q;

	// Owner entries are only trusted once the frame is busy, so they need no reset.
	always_ff @(posedge clk) begin
		if (wr.en && wr.owner_en) begin
			owner_q[wr.idx] <= wr.owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (wr.en) begin
			stamp_q[wr.idx] <= wr.stamp;
			if (wr.owner_en) begin
				busy_q[wr.idx] <= 1'b1;
			end
		end
	end

	assign rd_entry.busy  = busy_q[rd_idx];
	assign rd_entry.owner = owner_q[rd_idx];
	assign rd_entry.stamp = stamp_q[rd_idx];

endmodule

### rtl/rpfr_cmp.sv
module rpfr_cmp
	import rpfr_pkg::*;
(
	input  frame_entry_t       entry,
	input  logic [PAGE_W-1:0]  page,
	input  logic               have_busy,
	input  logic [STAMP_W-1:0] min_stamp,
	output cmp_res_t           res
);

	// A busy frame is older only when strictly below the best so far, so the
	// lowest index keeps ties.
	assign res.match = entry.busy && (entry.owner == page);
	assign res.free  = !entry.busy;
	assign res.older = entry.busy && (!have_busy || (entry.stamp < min_stamp));

endmodule

### rtl/rom_page_frame_replacement_top.sv
// Out of range, the request passes through the flush state into the output register.
// In range, the scan visits the frames in order (up to 16, a hit stops the scan early),
// then the update state writes the table and the output register. Flush and update
// both wait for a free output slot. One item at a time; in_ready is high only when idle.
// The sequential scan through the frame table by the single compare unit sets the rate.
// Reset (arst_n low): all frames free, all stamps and the use clock zero, rom_size zero.
module rom_page_frame_replacement_top
	import rpfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  logic [SIZE_W-1:0]   cfg_wdata,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADDR_W-1:0]   location,

	output logic                out_valid,
	input  logic                out_ready,
	output logic                in_range,
	output logic                hit,
	output logic [FRAME_W-1:0]  frame,
	output logic [OFFS_W-1:0]   page_offset,
	output logic [PAGE_W-1:0]   fill_page,
	output logic                evicted_valid,
	output logic [PAGE_W-1:0]   evicted_page
);

	// The page map of the classic scheme is not kept as its own store. A page
	// is mapped exactly when some busy frame names it as owner, and at most
	// one frame can, so the lookup is done by scanning the frame table. This
	// replaces a 2048-entry map (and its reset clearing) with the same scan
	// that the miss path needs anyway to find a free or least recent frame.

	state_t state_q;

	logic [SIZE_W-1:0]  rom_size_q;
	logic [STAMP_W-1:0] use_clock_q;

	// Transaction being worked on.
	logic [PAGE_W-1:0]  page_q;
	logic [OFFS_W-1:0]  offs_q;

	// Scan bookkeeping.
	logic [FRAME_W-1:0] scan_q;
	logic               hit_q;
	logic [FRAME_W-1:0] hit_idx_q;
	logic               free_q;
	logic [FRAME_W-1:0] free_idx_q;
	logic               have_busy_q;
	logic [FRAME_W-1:0] min_idx_q;
	logic [STAMP_W-1:0] min_stamp_q;

	logic               out_valid_q;

	logic [FRAME_W-1:0] rd_idx;
	frame_entry_t       rd_entry;
	frame_wr_t          tbl_wr;
	cmp_res_t           cmp;

	logic               accept;
	logic               slot_free;
	logic               loc_in_range;
	logic               commit;
	logic [STAMP_W-1:0] next_clock;
	logic [FRAME_W-1:0] victim;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign slot_free    = !out_valid_q || out_ready;
	assign loc_in_range = {1'b0, location[LOC_W-1:0]} < rom_size_q;
	assign commit       = (state_q == ST_UPDATE) && slot_free;
	assign next_clock   = use_clock_q + STAMP_W'(1);

	// A free frame always wins over eviction; otherwise the oldest busy frame goes.
	assign victim = free_q ? free_idx_q : min_idx_q;

	// During the scan the table is read at the scan position. In the update
	// cycle it is read at the oldest frame so that its owner can be reported
	// as the evicted page.
	assign rd_idx = (state_q == ST_SCAN) ? scan_q : min_idx_q;

	rpfr_frame_tbl u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.wr       (tbl_wr)
	);

	rpfr_cmp u_cmp (
		.entry     (rd_entry),
		.page      (page_q),
		.have_busy (have_busy_q),
		.min_stamp (min_stamp_q),
		.res       (cmp)
	);

	// A hit only refreshes the stamp; a miss also claims the frame for the new page.
	always_comb begin
		tbl_wr.en       = commit;
		tbl_wr.idx      = hit_q ? hit_idx_q : victim;
		tbl_wr.owner_en = !hit_q;
		tbl_wr.owner    = page_q;
		tbl_wr.stamp    = next_clock;
	end

	// The user must write the configuration register only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size_q <= '0;
		end else if (cfg_we) begin
			rom_size_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			have_busy_q <= 1'b0;
			use_clock_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q      <= '0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						have_busy_q <= 1'b0;
						// The page number always fits the map, so only the size
						// check can reject a location.
						state_q     <= loc_in_range ? ST_SCAN : ST_FLUSH;
					end
				end
				ST_SCAN: begin
					if (cmp.match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						if (cmp.free) begin
							free_q <= 1'b1;
						end
						if (cmp.older) begin
							have_busy_q <= 1'b1;
						end
						if (scan_q == LAST_FRAME) begin
							state_q <= ST_UPDATE;
						end
						scan_q <= scan_q + FRAME_W'(1);
					end
				end
				ST_UPDATE: begin
					if (slot_free) begin
						use_clock_q <= next_clock;
						state_q     <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan datapath registers; their contents only matter inside a transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= location[LOC_W-1:OFFS_W];
			offs_q <= location[OFFS_W-1:0];
		end
		if (state_q == ST_SCAN) begin
			if (cmp.match) begin
				hit_idx_q <= scan_q;
			end
			// Only the first free frame counts.
			if (cmp.free && !free_q) begin
				free_idx_q <= scan_q;
			end
			if (cmp.older) begin
				min_idx_q   <= scan_q;
				min_stamp_q <= rd_entry.stamp;
			end
		end
	end

	// Output register. It holds a finished result until the consumer takes it,
	// while the sequencer may already accept and scan the next transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit || ((state_q == ST_FLUSH) && slot_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			in_range      <= 1'b1;
			hit           <= hit_q;
			frame         <= hit_q ? hit_idx_q : victim;
			page_offset   <= offs_q;
			fill_page     <= hit_q ? '0 : page_q;
			evicted_valid <= !hit_q && !free_q;
			evicted_page  <= (!hit_q && !free_q) ? rd_entry.owner : '0;
		end else if ((state_q == ST_FLUSH) && slot_free) begin
			// Out of range: every field reads zero.
			in_range      <= 1'b0;
			hit           <= 1'b0;
			frame         <= '0;
			page_offset   <= '0;
			fill_page     <= '0;
			evicted_valid <= 1'b0;
			evicted_page  <= '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
